// ----- hw/rtl/pfp_pkg.sv -----
package pfp_pkg;

   localparam int CoordWidth = 32;
   localparam int EdgeW      = CoordWidth + 1;
   localparam int ProdW      = 2 * EdgeW;
   localparam int CrossW     = ProdW + 2;
   localparam int MagW       = CrossW - 1;
   localparam int ShW        = $clog2(MagW + 1);
   localparam int VecW       = 31;
   localparam int SqW        = 2 * VecW + 2;
   localparam int RootW      = SqW / 2;
   localparam int RemW       = RootW + 3;
   localparam int OneShift   = 30;
   localparam int QuotW      = OneShift + 1;
   localparam int DivW       = VecW + OneShift + 1;
   localparam int DivRemW    = RootW + 1;
   localparam int NormW      = 32;
   localparam int OffW       = 48;
   localparam int NpW        = NormW + CoordWidth;
   localparam int SumW       = NpW + 2;

   localparam int SqrtStages = 8;
   localparam int SqrtIter   = RootW / SqrtStages;
   localparam int DivStages  = 8;
   localparam int DivIter    = (QuotW + DivStages - 1) / DivStages;

   typedef logic [2:0][CoordWidth-1:0] coord3_type;
   typedef logic [2:0][VecW-1:0]       vec3_type;
   typedef logic [2:0][QuotW-1:0]      quot3_type;

   typedef struct packed {
      logic                          command;
      logic signed [CoordWidth-1:0]  p0_x;
      logic signed [CoordWidth-1:0]  p0_y;
      logic signed [CoordWidth-1:0]  p0_z;
      logic signed [CoordWidth-1:0]  p1_x;
      logic signed [CoordWidth-1:0]  p1_y;
      logic signed [CoordWidth-1:0]  p1_z;
      logic signed [CoordWidth-1:0]  p2_x;
      logic signed [CoordWidth-1:0]  p2_y;
      logic signed [CoordWidth-1:0]  p2_z;
   } req_type;

   typedef struct packed {
      logic signed [NormW-1:0] normal_x;
      logic signed [NormW-1:0] normal_y;
      logic signed [NormW-1:0] normal_z;
      logic signed [OffW-1:0]  offset_d;
      logic                    degenerate;
   } rsp_type;

   typedef struct packed {
      logic [2:0][CrossW-1:0] c;
      coord3_type             p0;
   } cross_type;

   typedef struct packed {
      vec3_type   v;
      logic [2:0] neg;
      logic       degen;
      coord3_type p0;
   } vec_type;

endpackage

// ----- hw/rtl/plane_from_three_points.sv -----
// Pipeline from an accepted req word to its rsp word: cross product, scaling and
//   sum of squares, square root, rounding divide, offset.
// Throughput: one word per cycle; one enable moves the whole pipeline, so a stalled
//   rsp word freezes every stage and req_stall rises in the same cycle.
// Reset: synchronous, active high; clears only the stage valid bits.
module plane_from_three_points (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pfp_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pfp_pkg::rsp_type rsp_word
);
   import pfp_pkg::*;

   logic      adv;
   logic      cr_valid, nm_valid, sq_valid, dv_valid;
   cross_type cr_word;
   vec_type   nm_side, sq_side, dv_side;
   logic [SqW-1:0]   nm_sq;
   logic [RootW-1:0] sq_root;
   quot3_type        dv_quot;

   // advance whenever the output register is empty or being drained
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // edge vectors and exact wide cross product
   pfp_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .out_valid (cr_valid),
      .out_word  (cr_word)
   );

   // scale to 31-bit magnitudes and form the sum of squares
   pfp_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (cr_valid),
      .in_word   (cr_word),
      .out_valid (nm_valid),
      .out_side  (nm_side),
      .out_sq    (nm_sq)
   );

   // integer square root, four result bits per stage
   pfp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (nm_valid),
      .in_side   (nm_side),
      .in_sq     (nm_sq),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   // three rounded dividers in lockstep give the Q1.30 normal magnitudes
   pfp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_side   (sq_side),
      .in_root   (sq_root),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_quot  (dv_quot)
   );

   // apply signs, zero a degenerate result, form d = -(n . p0); holds the rsp register
   pfp_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (dv_valid),
      .in_side   (dv_side),
      .in_quot   (dv_quot),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

endmodule

// ----- hw/rtl/pfp_cross.sv -----
module pfp_cross (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  pfp_pkg::req_type   in_word,
   output logic               out_valid,
   output pfp_pkg::cross_type out_word
);
   import pfp_pkg::*;

   logic [2:0]              v_ff, v_in;
   logic signed [EdgeW-1:0] e1_ff [3], e2_ff [3], e1_in [3], e2_in [3];
   logic signed [ProdW-1:0] pa_ff [3], pb_ff [3], pa_in [3], pb_in [3];
   coord3_type              p0_in, p1_in, p2_in, p0a_ff, p0b_ff;
   logic                    ccwa_ff, ccwb_ff;
   cross_type               word_in, word_ff;

   always_comb begin
      int j, k;
      logic signed [CrossW-1:0] diff;
      p0_in = {in_word.p0_z, in_word.p0_y, in_word.p0_x};
      p1_in = {in_word.p1_z, in_word.p1_y, in_word.p1_x};
      p2_in = {in_word.p2_z, in_word.p2_y, in_word.p2_x};
      // edges from point 0
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = {p1_in[i][CoordWidth-1], p1_in[i]} - {p0_in[i][CoordWidth-1], p0_in[i]};
         e2_in[i] = {p2_in[i][CoordWidth-1], p2_in[i]} - {p0_in[i][CoordWidth-1], p0_in[i]};
      end
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         pa_in[i] = e1_ff[j] * e2_ff[k];
         pb_in[i] = e1_ff[k] * e2_ff[j];
      end
      // flip sign for clockwise winding
      for (int i = 0; i < 3; i++) begin
         diff = CrossW'(pa_ff[i]) - CrossW'(pb_ff[i]);
         word_in.c[i] = ccwb_ff ? diff : -diff;
      end
      word_in.p0 = p0b_ff;
      v_in = {v_ff[1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff   <= e1_in;
         e2_ff   <= e2_in;
         p0a_ff  <= p0_in;
         ccwa_ff <= in_word.command;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         p0b_ff  <= p0a_ff;
         ccwb_ff <= ccwa_ff;
         word_ff <= word_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_word  = word_ff;

endmodule

// ----- hw/rtl/pfp_norm.sv -----
module pfp_norm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  pfp_pkg::cross_type   in_word,
   output logic                 out_valid,
   output pfp_pkg::vec_type     out_side,
   output logic [pfp_pkg::SqW-1:0] out_sq
);
   import pfp_pkg::*;

   logic [4:0]          v_ff, v_in;
   logic [MagW-1:0]     maga_ff [3], maga_in [3], magb_ff [3];
   logic [2:0]          nega_ff, nega_in, negb_ff;
   coord3_type          p0a_ff, p0b_ff;
   logic [ShW-1:0]      len_ff, len_in;
   logic                degb_ff;
   vec_type             vc_ff, vc_in, vd_ff, ve_ff;
   logic [2*VecW-1:0]   sq_ff [3], sq_in [3];
   logic [SqW-1:0]      sum_ff, sum_in;

   always_comb begin
      logic [CrossW-1:0]    cn;
      logic [MagW-1:0]      any;
      logic [MagW+VecW-1:0] sh;
      for (int i = 0; i < 3; i++) begin
         cn         = -in_word.c[i];
         nega_in[i] = in_word.c[i][CrossW-1];
         maga_in[i] = nega_in[i] ? cn[MagW-1:0] : in_word.c[i][MagW-1:0];
      end
      // bit length of the largest magnitude
      any    = maga_ff[0] | maga_ff[1] | maga_ff[2];
      len_in = '0;
      for (int b = 0; b < MagW; b++) begin
         if (any[b]) len_in = ShW'(b + 1);
      end
      // scale to VecW bits: right when longer, left when shorter
      for (int i = 0; i < 3; i++) begin
         sh           = {magb_ff[i], {VecW{1'b0}}} >> len_ff;
         vc_in.v[i]   = sh[VecW-1:0];
      end
      vc_in.neg   = negb_ff;
      vc_in.degen = degb_ff;
      vc_in.p0    = p0b_ff;
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = vc_ff.v[i] * vc_ff.v[i];
      end
      sum_in = SqW'(sq_ff[0]) + SqW'(sq_ff[1]) + SqW'(sq_ff[2]);
      v_in   = {v_ff[3:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         maga_ff <= maga_in;
         nega_ff <= nega_in;
         p0a_ff  <= in_word.p0;
         magb_ff <= maga_ff;
         negb_ff <= nega_ff;
         p0b_ff  <= p0a_ff;
         len_ff  <= len_in;
         degb_ff <= (len_in == '0);
         vc_ff   <= vc_in;
         sq_ff   <= sq_in;
         vd_ff   <= vc_ff;
         sum_ff  <= sum_in;
         ve_ff   <= vd_ff;
      end
   end

   assign out_valid = v_ff[4];
   assign out_side  = ve_ff;
   assign out_sq    = sum_ff;

endmodule

// ----- hw/rtl/pfp_sqrt.sv -----
module pfp_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  pfp_pkg::vec_type          in_side,
   input  logic [pfp_pkg::SqW-1:0]   in_sq,
   output logic                      out_valid,
   output pfp_pkg::vec_type          out_side,
   output logic [pfp_pkg::RootW-1:0] out_root
);
   import pfp_pkg::*;

   logic [SqrtStages-1:0] v_ff, v_in;
   logic [SqW-1:0]        rad_ff [SqrtStages], rad_in [SqrtStages];
   logic [RemW-1:0]       rem_ff [SqrtStages], rem_in [SqrtStages];
   logic [RootW-1:0]      rt_ff  [SqrtStages], rt_in  [SqrtStages];
   vec_type               sd_ff  [SqrtStages], sd_in  [SqrtStages];

   // two radicand bits per step, SqrtIter steps per stage
   always_comb begin
      logic [SqW-1:0]   r;
      logic [RemW-1:0]  rm, t;
      logic [RootW-1:0] rt;
      for (int s = 0; s < SqrtStages; s++) begin
         r  = (s == 0) ? in_sq : rad_ff[s-1];
         rm = (s == 0) ? '0 : rem_ff[s-1];
         rt = (s == 0) ? '0 : rt_ff[s-1];
         for (int it = 0; it < SqrtIter; it++) begin
            rm = {rm[RemW-3:0], r[SqW-1:SqW-2]};
            r  = {r[SqW-3:0], 2'b00};
            t  = {1'b0, rt, 2'b01};
            if (rm >= t) begin
               rm = rm - t;
               rt = {rt[RootW-2:0], 1'b1};
            end else begin
               rt = {rt[RootW-2:0], 1'b0};
            end
         end
         rad_in[s] = r;
         rem_in[s] = rm;
         rt_in[s]  = rt;
         sd_in[s]  = (s == 0) ? in_side : sd_ff[s-1];
      end
      v_in = {v_ff[SqrtStages-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= rad_in;
         rem_ff <= rem_in;
         rt_ff  <= rt_in;
         sd_ff  <= sd_in;
      end
   end

   assign out_valid = v_ff[SqrtStages-1];
   assign out_side  = sd_ff[SqrtStages-1];
   assign out_root  = rt_ff[SqrtStages-1];

endmodule

// ----- hw/rtl/pfp_div.sv -----
module pfp_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  pfp_pkg::vec_type          in_side,
   input  logic [pfp_pkg::RootW-1:0] in_root,
   output logic                      out_valid,
   output pfp_pkg::vec_type          out_side,
   output pfp_pkg::quot3_type        out_quot
);
   import pfp_pkg::*;

   localparam int Depth = DivStages + 1;

   logic [Depth-1:0]   v_ff, v_in;
   logic [DivRemW-1:0] rem_ff [Depth][3], rem_in [Depth][3];
   logic [QuotW-1:0]   low_ff [Depth][3], low_in [Depth][3];
   logic [QuotW-1:0]   q_ff   [Depth][3], q_in   [Depth][3];
   logic [RootW-1:0]   m_ff   [Depth],    m_in   [Depth];
   vec_type            sd_ff  [Depth],    sd_in  [Depth];

   // first stage: rounded dividend v * 2^30 + m/2, then one quotient bit per step
   always_comb begin
      logic [DivW-1:0]    n;
      logic [DivRemW-1:0] rm;
      logic [QuotW-1:0]   lo, q;
      for (int i = 0; i < 3; i++) begin
         n            = {1'b0, in_side.v[i], {OneShift{1'b0}}} + DivW'(in_root >> 1);
         rem_in[0][i] = DivRemW'(n[DivW-1:QuotW]);
         low_in[0][i] = n[QuotW-1:0];
         q_in[0][i]   = '0;
      end
      m_in[0]  = in_root;
      sd_in[0] = in_side;
      for (int s = 1; s < Depth; s++) begin
         for (int i = 0; i < 3; i++) begin
            rm = rem_ff[s-1][i];
            lo = low_ff[s-1][i];
            q  = q_ff[s-1][i];
            for (int it = 0; it < DivIter; it++) begin
               if ((s - 1) * DivIter + it < QuotW) begin
                  rm = {rm[DivRemW-2:0], lo[QuotW-1]};
                  lo = {lo[QuotW-2:0], 1'b0};
                  if (rm >= {1'b0, m_ff[s-1]}) begin
                     rm = rm - {1'b0, m_ff[s-1]};
                     q  = {q[QuotW-2:0], 1'b1};
                  end else begin
                     q  = {q[QuotW-2:0], 1'b0};
                  end
               end
            end
            rem_in[s][i] = rm;
            low_in[s][i] = lo;
            q_in[s][i]   = q;
         end
         m_in[s]  = m_ff[s-1];
         sd_in[s] = sd_ff[s-1];
      end
      v_in = {v_ff[Depth-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         q_ff   <= q_in;
         m_ff   <= m_in;
         sd_ff  <= sd_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_quot[i] = q_ff[Depth-1][i];
      end
   end

   assign out_valid = v_ff[Depth-1];
   assign out_side  = sd_ff[Depth-1];

endmodule

// ----- hw/rtl/pfp_offset.sv -----
module pfp_offset (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  pfp_pkg::vec_type   in_side,
   input  pfp_pkg::quot3_type in_quot,
   output logic               out_valid,
   output pfp_pkg::rsp_type   out_word
);
   import pfp_pkg::*;

   logic [3:0]              v_ff, v_in;
   logic signed [NormW-1:0] na_ff [3], na_in [3], nb_ff [3], nc_ff [3];
   logic signed [NpW-1:0]   pr_ff [3], pr_in [3];
   logic signed [SumW-1:0]  s_ff, s_in;
   coord3_type              p0_ff;
   logic [2:0]              dg_ff;
   rsp_type                 word_in, word_ff;

   always_comb begin
      logic [NormW-1:0]       qe;
      logic signed [SumW-1:0] dsh;
      for (int i = 0; i < 3; i++) begin
         qe = {1'b0, in_quot[i]};
         if (in_side.degen) begin
            na_in[i] = '0;
         end else begin
            na_in[i] = in_side.neg[i] ? -qe : qe;
         end
      end
      for (int i = 0; i < 3; i++) begin
         pr_in[i] = na_ff[i] * $signed(p0_ff[i]);
      end
      // negate the dot product and add half an LSB before the shift
      s_in = -(SumW'(pr_ff[0]) + SumW'(pr_ff[1]) + SumW'(pr_ff[2]))
             + (SumW'(1) <<< (OneShift - 1));
      dsh  = s_ff >>> OneShift;
      // clamp to the signed OffW range
      if (dsh > SumW'((64'sd1 <<< (OffW - 1)) - 64'sd1)) begin
         word_in.offset_d = {1'b0, {(OffW-1){1'b1}}};
      end else if (dsh < -(SumW'(64'sd1 <<< (OffW - 1)))) begin
         word_in.offset_d = {1'b1, {(OffW-1){1'b0}}};
      end else begin
         word_in.offset_d = dsh[OffW-1:0];
      end
      word_in.normal_x   = nc_ff[0];
      word_in.normal_y   = nc_ff[1];
      word_in.normal_z   = nc_ff[2];
      word_in.degenerate = dg_ff[2];
      v_in = {v_ff[2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         na_ff   <= na_in;
         p0_ff   <= in_side.p0;
         pr_ff   <= pr_in;
         nb_ff   <= na_ff;
         s_ff    <= s_in;
         nc_ff   <= nb_ff;
         dg_ff   <= {dg_ff[1:0], in_side.degen};
         word_ff <= word_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_word  = word_ff;

endmodule
